// File: hw/rtl/csft_pkg.sv
// csft_pkg: shared types and constants for the CAN subscription filter table.
// Item structs, request and status codes, table sizing.
// No dependencies.
`timescale 1ns / 1ps

package csft_pkg;

  localparam int ENTRIES    = 16;
  localparam int RESULT_CAP = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int ID_W       = 29;
  localparam int HANDLE_W   = 8;
  localparam int SLOT_W     = 4;
  localparam int DATA_W     = 64;
  localparam int LEN_W      = 4;

  localparam logic [1:0] REQ_ATTACH   = 2'd0;
  localparam logic [1:0] REQ_DETACH   = 2'd1;
  localparam logic [1:0] REQ_FRAME    = 2'd2;
  // taken and dropped without a result
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    ST_ATTACHED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_FULL        = 3'd2,
    ST_DETACHED    = 3'd3,
    ST_DETACH_NONE = 3'd4,
    ST_DELIVERED   = 3'd5,
    ST_NO_MATCH    = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] observer_handle;
    logic [ID_W-1:0]     can_id;
    logic [ID_W-1:0]     mask_bits;
    logic                extended;
    logic [DATA_W-1:0]   frame_data;
    logic [LEN_W-1:0]    frame_length;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] observer_handle_out;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     frame_id_out;
    logic [DATA_W-1:0]   frame_data_out;
    logic [LEN_W-1:0]    frame_length_out;
    logic                last;
  } out_item_t;

  // one table entry as kept in the entry memory
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    logic [ID_W-1:0]     mask;
    logic                ext;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

endpackage

// File: hw/rtl/csft_ram.sv
// csft_ram: generic single-write, single-read memory with registered read.
// Used for the entry store of the filter table; no dependencies.
`timescale 1ns / 1ps

module csft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: hw/rtl/can_subscription_filter_table.sv
// can_subscription_filter_table: attach/detach subscribers and dispatch frames.
// Uses csft_pkg and csft_ram (entry store); valid marks kept in flip-flops.
`timescale 1ns / 1ps

//  channel | ports                     | handshake
//  --------+---------------------------+--------------------------------------
//  input   | start, busy, in_item      | taken when start is high, busy low
//  result  | out_valid, out_item       | one-cycle strobe, cannot be held off
//
//  every attach, detach and frame request scans all ENTRIES slots through the
//  entry memory, one read per cycle; busy stays high through the scan, the
//  registered memory read and the finish state; the result cap cuts a dispatch
//  short only when ENTRIES exceeds it. deliveries come out while the scan runs,
//  the final result after it. the valid marks clear on reset, the entry memory
//  needs no clearing. request type three is taken and dropped without a result.

module can_subscription_filter_table
  import csft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(RESULT_CAP);

  state_t              state_r;
  in_item_t            req_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                iss_on_r;
  logic                chk_on_r;
  logic [IDX_W-1:0]    chk_idx_r;
  logic [ENTRIES-1:0]  valid_r;
  logic                hit_on_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic                pend_on_r;
  logic [HANDLE_W-1:0] pend_handle_r;
  logic [IDX_W-1:0]    pend_idx_r;
  logic [CNT_W-1:0]    n_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [ENT_W-1:0]    rd_data;
  entry_t              ent;
  logic                ent_valid;
  logic                same;
  logic                hit;
  logic                free_on;
  logic [IDX_W-1:0]    free_idx;
  logic                wr_en;
  entry_t              wr_ent;

  csft_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (wr_ent),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  assign ent       = entry_t'(rd_data);
  assign ent_valid = valid_r[chk_idx_r];
  assign same      = ent_valid && (ent.handle == req_r.observer_handle) &&
                     (ent.id == req_r.can_id) && (ent.mask == req_r.mask_bits);
  assign hit       = ent_valid &&
                     ((req_r.can_id & ent.mask) == (ent.id & ent.mask));

  // lowest free slot
  always_comb begin
    free_on  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_on  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign wr_en = (state_r == S_DONE) && (req_r.req_type == REQ_ATTACH) &&
                 !hit_on_r && free_on;

  always_comb begin
    wr_ent.handle = req_r.observer_handle;
    wr_ent.id     = req_r.can_id;
    wr_ent.mask   = req_r.mask_bits;
    wr_ent.ext    = req_r.extended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_on_r    <= 1'b0;
      chk_on_r    <= 1'b0;
      valid_r     <= '0;
      hit_on_r    <= 1'b0;
      pend_on_r   <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      chk_on_r    <= iss_on_r;
      chk_idx_r   <= scan_idx_r;
      if (iss_on_r) begin
        if (scan_idx_r == IDX_LAST) begin
          iss_on_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_item;
            if (in_item.req_type inside {REQ_ATTACH, REQ_DETACH, REQ_FRAME}) begin
              state_r    <= S_SCAN;
              scan_idx_r <= '0;
              iss_on_r   <= 1'b1;
              hit_on_r   <= 1'b0;
              pend_on_r  <= 1'b0;
              n_r        <= '0;
            end
          end
        end

        S_SCAN: begin
          if (chk_on_r) begin
            case (req_r.req_type)
              REQ_ATTACH: begin
                if (same && !hit_on_r) begin
                  hit_on_r  <= 1'b1;
                  hit_idx_r <= chk_idx_r;
                end
              end
              REQ_DETACH: begin
                if (same) begin
                  valid_r[chk_idx_r] <= 1'b0;
                  if (!hit_on_r) begin
                    hit_on_r  <= 1'b1;
                    hit_idx_r <= chk_idx_r;
                  end
                end
              end
              REQ_FRAME: begin
                if (hit) begin
                  // previous match is known not to be the last one now
                  if (pend_on_r) begin
                    out_valid_r                    <= 1'b1;
                    out_item_r.status              <= ST_DELIVERED;
                    out_item_r.observer_handle_out <= pend_handle_r;
                    out_item_r.slot                <= SLOT_W'(pend_idx_r);
                    out_item_r.frame_id_out        <= req_r.can_id;
                    out_item_r.frame_data_out      <= req_r.frame_data;
                    out_item_r.frame_length_out    <= req_r.frame_length;
                    out_item_r.last                <= 1'b0;
                  end
                  pend_on_r     <= 1'b1;
                  pend_handle_r <= ent.handle;
                  pend_idx_r    <= chk_idx_r;
                  n_r           <= n_r + 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (chk_idx_r == IDX_LAST) begin
              state_r <= S_DONE;
            end
            // result cap reached: stop scanning
            if (req_r.req_type == REQ_FRAME && hit && (CNT_W'(n_r + 1'b1) == CAP)) begin
              state_r  <= S_DONE;
              iss_on_r <= 1'b0;
              chk_on_r <= 1'b0;
            end
          end
        end

        S_DONE: begin
          state_r                        <= S_IDLE;
          out_valid_r                    <= 1'b1;
          out_item_r.observer_handle_out <= req_r.observer_handle;
          out_item_r.slot                <= '0;
          out_item_r.frame_id_out        <= '0;
          out_item_r.frame_data_out      <= '0;
          out_item_r.frame_length_out    <= '0;
          out_item_r.last                <= 1'b1;
          case (req_r.req_type)
            REQ_ATTACH: begin
              if (hit_on_r) begin
                out_item_r.status <= ST_DUPLICATE;
                out_item_r.slot   <= SLOT_W'(hit_idx_r);
              end else if (free_on) begin
                valid_r[free_idx] <= 1'b1;
                out_item_r.status <= ST_ATTACHED;
                out_item_r.slot   <= SLOT_W'(free_idx);
              end else begin
                out_item_r.status <= ST_FULL;
              end
            end
            REQ_DETACH: begin
              if (hit_on_r) begin
                out_item_r.status <= ST_DETACHED;
                out_item_r.slot   <= SLOT_W'(hit_idx_r);
              end else begin
                out_item_r.status <= ST_DETACH_NONE;
              end
            end
            default: begin
              out_item_r.frame_id_out     <= req_r.can_id;
              out_item_r.frame_data_out   <= req_r.frame_data;
              out_item_r.frame_length_out <= req_r.frame_length;
              if (pend_on_r) begin
                out_item_r.status              <= ST_DELIVERED;
                out_item_r.observer_handle_out <= pend_handle_r;
                out_item_r.slot                <= SLOT_W'(pend_idx_r);
              end else begin
                out_item_r.status              <= ST_NO_MATCH;
                out_item_r.observer_handle_out <= '0;
              end
            end
          endcase
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // an attach only ever fills a free slot
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !valid_r[free_idx])
    else $error("attach wrote over a valid slot");

  // nothing follows the final result of an item right away
  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result right after a final result");

  // memory compare stage only runs while a request is in progress
  a_chk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chk_on_r |-> busy)
    else $error("compare stage active while idle");

  // delivery count never passes the cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CAP)
    else $error("delivery count above cap");

  // a new request never starts with a result on the port
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result strobe at request start");

endmodule

// File: tb/tb_can_subscription_filter_table.sv
// tb_can_subscription_filter_table: self-checking bench for the subscription filter table.
// Drives attach, detach and frame requests with random gaps and checks every result.
// Depends on csft_pkg and the can_subscription_filter_table RTL.
`timescale 1ns / 1ps

module tb_can_subscription_filter_table
  import csft_pkg::*;
();

  // mirror of the subscriber table plus the queue of results still owed
  class filter_table_model;
    logic                valid  [ENTRIES];
    logic [HANDLE_W-1:0] handle [ENTRIES];
    logic [ID_W-1:0]     id     [ENTRIES];
    logic [ID_W-1:0]     mask   [ENTRIES];
    logic                ext    [ENTRIES];
    out_item_t           owed_results[$];
    int                  errors;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (valid[i]) if (valid[i]) n++;
      return n;
    endfunction

    // random valid slot, or -1 with an empty table
    function int pick_live();
      int live[$];
      foreach (valid[i]) if (valid[i]) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function int find_same(in_item_t it);
      for (int i = 0; i < ENTRIES; i++)
        if (valid[i] && handle[i] == it.observer_handle && id[i] == it.can_id &&
            mask[i] == it.mask_bits)
          return i;
      return -1;
    endfunction

    function void owe(status_t st, logic [HANDLE_W-1:0] h, int s,
                      logic [ID_W-1:0] fid, logic [DATA_W-1:0] fdata,
                      logic [LEN_W-1:0] flen, logic lst);
      out_item_t r;
      r = '0;
      r.status              = st;
      r.observer_handle_out = h;
      r.slot                = s[SLOT_W-1:0];
      r.frame_id_out        = fid;
      r.frame_data_out      = fdata;
      r.frame_length_out    = flen;
      r.last                = lst;
      owed_results.push_back(r);
    endfunction

    function void note_request(in_item_t it);
      int pos;
      int first;
      int hits;
      case (it.req_type)
        REQ_ATTACH: begin
          pos = find_same(it);
          if (pos >= 0) begin
            owe(ST_DUPLICATE, it.observer_handle, pos, '0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < ENTRIES && pos < 0; i++)
              if (!valid[i]) pos = i;
            if (pos >= 0) begin
              valid[pos]  = 1'b1;
              handle[pos] = it.observer_handle;
              id[pos]     = it.can_id;
              mask[pos]   = it.mask_bits;
              ext[pos]    = it.extended;
              owe(ST_ATTACHED, it.observer_handle, pos, '0, '0, '0, 1'b1);
            end else begin
              owe(ST_FULL, it.observer_handle, 0, '0, '0, '0, 1'b1);
            end
          end
        end
        REQ_DETACH: begin
          first = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && handle[i] == it.observer_handle && id[i] == it.can_id &&
                mask[i] == it.mask_bits) begin
              valid[i] = 1'b0;
              if (first < 0) first = i;
            end
          if (first >= 0) owe(ST_DETACHED, it.observer_handle, first, '0, '0, '0, 1'b1);
          else owe(ST_DETACH_NONE, it.observer_handle, 0, '0, '0, '0, 1'b1);
        end
        REQ_FRAME: begin
          hits = 0;
          for (int i = 0; i < ENTRIES && hits < RESULT_CAP; i++)
            if (valid[i] && ((it.can_id & mask[i]) == (id[i] & mask[i]))) begin
              owe(ST_DELIVERED, handle[i], i, it.can_id, it.frame_data, it.frame_length,
                  1'b0);
              hits++;
            end
          if (hits == 0)
            owe(ST_NO_MATCH, '0, 0, it.can_id, it.frame_data, it.frame_length, 1'b1);
          else
            owed_results[owed_results.size() - 1].last = 1'b1;
        end
        default: ;  // type three is dropped silently
      endcase
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual status %0d slot %0d",
                 $time, got.status, got.slot);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare("status", want.status, got.status);
      compare("observer_handle_out", want.observer_handle_out, got.observer_handle_out);
      compare("slot", want.slot, got.slot);
      compare("frame_id_out", want.frame_id_out, got.frame_id_out);
      compare("frame_data_out", want.frame_data_out, got.frame_data_out);
      compare("frame_length_out", want.frame_length_out, got.frame_length_out);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  filter_table_model   subs;
  bit                  quiet;
  logic [HANDLE_W-1:0] handle_pool [4];
  logic [ID_W-1:0]     id_pool     [8];
  logic [ID_W-1:0]     mask_pool   [4];

  can_subscription_filter_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // results first, then the item taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) subs.check_result(out_item);
      if (start && !busy) subs.note_request(in_item);
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom());
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 99) < 10) return LEN_W'($urandom_range(9, 15));
    return LEN_W'($urandom_range(0, 8));
  endfunction

  // unused fields still carry random bits so every input bit toggles
  function automatic in_item_t make_req(logic [1:0] req, logic [HANDLE_W-1:0] h,
                                        logic [ID_W-1:0] cid, logic [ID_W-1:0] m);
    in_item_t it;
    it.req_type        = req;
    it.observer_handle = h;
    it.can_id          = cid;
    it.mask_bits       = m;
    it.extended        = 1'($urandom());
    it.frame_data      = {$urandom(), $urandom()};
    it.frame_length    = rand_len();
    return it;
  endfunction

  // the gap counts from the first cycle the table could take the item
  task automatic send(input in_item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 32) gap = $urandom_range(1, 55);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until the table has answered everything
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (subs.pending() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    in_item_t it;
    int       sent;
    int       pick;
    int       roll;
    int       attach_w;

    subs    = new();
    quiet   = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    handle_pool = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
    mask_pool   = '{29'h0, 29'h1FFFFFFF, 29'h7FF, 29'h1FFFF800};
    id_pool[0]  = '0;
    id_pool[1]  = 29'h1FFFFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = rand_id();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, duplicates, extremes, fill to the cap, full, free and refill
    quiet = 1'b1;
    it = make_req(REQ_FRAME, '0, 29'h1FFFFFFF, '0);
    it.frame_data   = '1;
    it.frame_length = 4'd8;
    send(it);
    send(make_req(REQ_DETACH, 8'h12, 29'h123, 29'h7FF));
    it = make_req(REQ_ATTACH, '0, '0, '0);
    it.extended = 1'b0;
    send(it);
    send(it);
    it = make_req(REQ_ATTACH, 8'hFF, 29'h1FFFFFFF, 29'h1FFFFFFF);
    it.extended = 1'b1;
    send(it);
    it = make_req(REQ_FRAME, '0, 29'h1FFFFFFF, '0);
    it.frame_data   = '0;
    it.frame_length = 4'd0;
    send(it);
    it = make_req(REQ_FRAME, '0, '0, '0);
    it.frame_length = 4'd15;
    send(it);
    send(make_req(REQ_RESERVED, 8'h33, rand_id(), rand_id()));
    for (int i = 2; i < ENTRIES; i++)
      send(make_req(REQ_ATTACH, HANDLE_W'(i), rand_id(), '0));
    send(make_req(REQ_FRAME, '0, 29'h1FFFFFFF, '0));
    send(make_req(REQ_ATTACH, 8'h77, rand_id(), rand_id()));
    send(make_req(REQ_DETACH, '0, '0, '0));
    send(make_req(REQ_ATTACH, '0, '0, '0));
    drain(2000);

    // random: phases swing between draining and filling the table
    sent = 0;
    while (sent < 320) begin
      quiet = (sent >= 200 && sent < 260);
      if (sent == 160) drain(2000);
      attach_w = ((sent / 40) % 2 == 0) ? 20 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send(make_req(REQ_RESERVED, 8'($urandom()), rand_id(), rand_id()));
        continue;
      end else if (roll < 4 + attach_w) begin
        if ($urandom_range(0, 9) < 7)
          it = make_req(REQ_ATTACH, handle_pool[$urandom_range(0, 3)],
                        id_pool[$urandom_range(0, 7)], mask_pool[$urandom_range(0, 3)]);
        else
          it = make_req(REQ_ATTACH, 8'($urandom()), rand_id(), rand_id());
      end else if (roll < 29 + attach_w) begin
        pick = subs.pick_live();
        if (pick >= 0 && $urandom_range(0, 9) < 7)
          it = make_req(REQ_DETACH, subs.handle[pick], subs.id[pick], subs.mask[pick]);
        else
          it = make_req(REQ_DETACH, handle_pool[$urandom_range(0, 3)],
                        id_pool[$urandom_range(0, 7)], mask_pool[$urandom_range(0, 3)]);
      end else begin
        pick = subs.pick_live();
        if (pick >= 0 && $urandom_range(0, 9) < 6)
          it = make_req(REQ_FRAME, 8'($urandom()),
                        subs.id[pick] ^ (rand_id() & ~subs.mask[pick]), rand_id());
        else if ($urandom_range(0, 9) < 3)
          it = make_req(REQ_FRAME, 8'($urandom()), id_pool[$urandom_range(0, 7)],
                        rand_id());
        else
          it = make_req(REQ_FRAME, 8'($urandom()), rand_id(), rand_id());
      end
      send(it);
      sent++;
    end

    drain(4000);
    repeat (40) @(posedge clk);
    if (subs.pending() != 0) begin
      $display("%0t: results missing expected %0d more actual 0", $time, subs.pending());
      subs.errors++;
    end
    if (subs.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
